// ----- sv/dqcs_pkg.sv -----
// Package for the dual quadrature counter with speed measurement.
// Holds payload structs, request and register codes and the 4x step table.
// No dependencies.
package dqcs_pkg;

	localparam int COUNT_W  = 32;
	localparam int WINDOW_W = 24;
	localparam int GAIN_W   = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int REQ_W    = 2;
	localparam int Q_SHIFT  = 16;

	localparam logic [REQ_W-1:0] REQ_SAMPLE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SNAPSHOT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_INVERT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_INVERT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 2'd3;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd1000;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd65536;

	typedef struct packed {
		logic             left_a;
		logic             left_b;
		logic             right_a;
		logic             right_b;
		logic [REQ_W-1:0] req_type;
	} sample_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
		logic signed [COUNT_W-1:0] left_speed;
		logic signed [COUNT_W-1:0] right_speed;
		logic                      speed_valid;
	} result_t;

	// 4x decode: index is {previous AB, current AB}, A is the high bit.
	// Returns a 2-bit signed step of -1, 0 or +1.
	function automatic logic signed [1:0] quad_step(input logic [1:0] prev_ab,
			input logic [1:0] cur_ab);
		logic signed [1:0] step;
		step = 2'sd0;
		case ({prev_ab, cur_ab})
			4'b0001, 4'b0111, 4'b1000, 4'b1110: step = -2'sd1;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: step = 2'sd1;
			default: step = 2'sd0;
		endcase
		return step;
	endfunction

endpackage

// ----- sv/dual_quadrature_counter_speed.sv -----
// Dual 4x quadrature counter with windowed speed measurement, top level.
// Depends on dqcs_pkg (payload structs, codes, step table).
// An accepted item moves through the input, stage 2, stage 3 and result registers (4-stage pipe).
// Throughput: one item per cycle; the pipe freezes only while result is full
// and stalled, and the count/window update is a loop closed within stage 1.
// Reset: arst_n clears counts, baselines, window, held speeds and valid flags, and loads register defaults.
module dual_quadrature_counter_speed (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  dqcs_pkg::sample_t             sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output dqcs_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [dqcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dqcs_pkg::CFG_W-1:0]    cfg_data
);
	import dqcs_pkg::*;

	localparam logic [WINDOW_W-1:0] WINDOW_ONE = {{(WINDOW_W-1){1'b0}}, 1'b1};
	localparam int PROD_W = 2 * COUNT_W;
	localparam int Q_W    = 2 * COUNT_W - Q_SHIFT;

	// Configuration registers
	logic                left_invert_q;
	logic                right_invert_q;
	logic [WINDOW_W-1:0] sample_window_q;
	logic [GAIN_W-1:0]   speed_gain_q;

	// Decoder state, updated in stage 1
	logic                primed_q;
	logic [1:0]          left_prev_ab_q;
	logic [1:0]          right_prev_ab_q;
	logic [COUNT_W-1:0]  left_total_q;
	logic [COUNT_W-1:0]  right_total_q;
	logic [COUNT_W-1:0]  left_base_q;
	logic [COUNT_W-1:0]  right_base_q;
	logic [WINDOW_W-1:0] window_ticks_q;
	logic [COUNT_W-1:0]  left_speed_hold_q;
	logic [COUNT_W-1:0]  right_speed_hold_q;

	// Pipeline registers
	logic                valid_s1;
	sample_t             sample_s1;
	logic                valid_s2;
	logic                win_s2;
	logic [COUNT_W-1:0]  left_count_s2;
	logic [COUNT_W-1:0]  right_count_s2;
	logic signed [COUNT_W-1:0] left_delta_s2;
	logic signed [COUNT_W-1:0] right_delta_s2;
	logic                valid_s3;
	logic                win_s3;
	logic [COUNT_W-1:0]  left_count_s3;
	logic [COUNT_W-1:0]  right_count_s3;
	logic signed [2*COUNT_W-1:0] left_prod_s3;
	logic signed [2*COUNT_W-1:0] right_prod_s3;
	logic                result_valid_q;
	result_t             result_q;

	// Stage 1 combinational
	logic                adv;
	logic [1:0]          left_ab;
	logic [1:0]          right_ab;
	logic [COUNT_W-1:0]  left_upd;
	logic [COUNT_W-1:0]  right_upd;
	logic [WINDOW_W-1:0] win_len;
	logic [WINDOW_W-1:0] ticks_inc;
	logic                is_clear;
	logic                is_snap;
	logic                win_done;
	logic [COUNT_W-1:0]  left_diff;
	logic [COUNT_W-1:0]  right_diff;

	// Stage 2 and 3 combinational
	logic signed [PROD_W-1:0] left_prod;
	logic signed [PROD_W-1:0] right_prod;
	logic [COUNT_W-1:0]  left_speed_new;
	logic [COUNT_W-1:0]  right_speed_new;

	function automatic logic [COUNT_W-1:0] apply_sign(input logic [COUNT_W-1:0] v,
			input logic inv);
		return inv ? (~v + {{(COUNT_W-1){1'b0}}, 1'b1}) : v;
	endfunction

	// Floor-shift the Q16 product and clamp to the signed 32-bit range.
	function automatic logic [COUNT_W-1:0] scale_sat(input logic signed [2*COUNT_W-1:0] p);
		logic signed [Q_W-1:0] q;
		logic                  fits;
		q    = Q_W'(p >>> Q_SHIFT);
		fits = (q[Q_W-1:COUNT_W-1] == '0) || (q[Q_W-1:COUNT_W-1] == '1);
		if (fits)
			return q[COUNT_W-1:0];
		else if (q[Q_W-1])
			return {1'b1, {(COUNT_W-1){1'b0}}};
		else
			return {1'b0, {(COUNT_W-1){1'b1}}};
	endfunction

	// The whole pipe moves together; hold everything while the result waits.
	assign adv          = !(result_valid_q && result_stall);
	assign sample_stall = !adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes must arrive only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_invert_q   <= 1'b0;
			right_invert_q  <= 1'b0;
			sample_window_q <= WINDOW_RESET;
			speed_gain_q    <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEFT_INVERT:   left_invert_q   <= cfg_data[0];
				CFG_RIGHT_INVERT:  right_invert_q  <= cfg_data[0];
				CFG_SAMPLE_WINDOW: sample_window_q <= cfg_data[WINDOW_W-1:0];
				CFG_SPEED_GAIN:    speed_gain_q    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
		end
	end

	// Stage 1: decode the pin change, advance counts and the window counter.
	always_comb begin
		left_ab  = {sample_s1.left_a, sample_s1.left_b};
		right_ab = {sample_s1.right_a, sample_s1.right_b};
		// First tick after reset only captures the pins.
		left_upd  = primed_q ? left_total_q + COUNT_W'(quad_step(left_prev_ab_q, left_ab))
			: left_total_q;
		right_upd = primed_q ? right_total_q + COUNT_W'(quad_step(right_prev_ab_q, right_ab))
			: right_total_q;
		is_clear  = (sample_s1.req_type == REQ_CLEAR);
		is_snap   = (sample_s1.req_type == REQ_SNAPSHOT);
		// A zero window behaves as one tick.
		win_len   = (sample_window_q == '0) ? WINDOW_ONE : sample_window_q;
		ticks_inc = window_ticks_q + WINDOW_ONE;
		win_done  = !is_clear && (ticks_inc >= win_len);
		left_diff  = apply_sign(left_upd - left_base_q, left_invert_q);
		right_diff = apply_sign(right_upd - right_base_q, right_invert_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q        <= 1'b0;
			left_prev_ab_q  <= 2'b00;
			right_prev_ab_q <= 2'b00;
			left_total_q    <= '0;
			right_total_q   <= '0;
			left_base_q     <= '0;
			right_base_q    <= '0;
			window_ticks_q  <= '0;
		end else if (adv && valid_s1) begin
			primed_q        <= 1'b1;
			left_prev_ab_q  <= left_ab;
			right_prev_ab_q <= right_ab;
			if (is_clear) begin
				// Drop counts, baselines and the partial window.
				left_total_q   <= '0;
				right_total_q  <= '0;
				left_base_q    <= '0;
				right_base_q   <= '0;
				window_ticks_q <= '0;
			end else begin
				// Snapshot zeroes the counts after they are reported.
				left_total_q  <= is_snap ? '0 : left_upd;
				right_total_q <= is_snap ? '0 : right_upd;
				if (win_done) begin
					left_base_q    <= left_upd;
					right_base_q   <= right_upd;
					window_ticks_q <= '0;
				end else begin
					window_ticks_q <= ticks_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s2         <= win_done;
			left_count_s2  <= is_clear ? '0 : apply_sign(left_upd, left_invert_q);
			right_count_s2 <= is_clear ? '0 : apply_sign(right_upd, right_invert_q);
			left_delta_s2  <= left_diff;
			right_delta_s2 <= right_diff;
		end
	end

	// Stage 2: signed delta times unsigned Q16 gain; the product fits in 64 bits.
	assign left_prod  = $signed({left_delta_s2[COUNT_W-1], left_delta_s2})
		* $signed({1'b0, speed_gain_q});
	assign right_prod = $signed({right_delta_s2[COUNT_W-1], right_delta_s2})
		* $signed({1'b0, speed_gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s3         <= win_s2;
			left_count_s3  <= left_count_s2;
			right_count_s3 <= right_count_s2;
			left_prod_s3   <= left_prod[2*COUNT_W-1:0];
			right_prod_s3  <= right_prod[2*COUNT_W-1:0];
		end
	end

	// Stage 3: scale, saturate, and refresh the held speeds on a window end.
	assign left_speed_new  = win_s3 ? scale_sat(left_prod_s3) : left_speed_hold_q;
	assign right_speed_new = win_s3 ? scale_sat(right_prod_s3) : right_speed_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_speed_hold_q  <= '0;
			right_speed_hold_q <= '0;
			result_valid_q     <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s3;
			if (valid_s3) begin
				left_speed_hold_q  <= left_speed_new;
				right_speed_hold_q <= right_speed_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.left_count  <= left_count_s3;
			result_q.right_count <= right_count_s3;
			result_q.left_speed  <= left_speed_new;
			result_q.right_speed <= right_speed_new;
			result_q.speed_valid <= win_s3;
		end
	end

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for the dual quadrature counter with speed measurement.
// Depends on dqcs_pkg (sample_t, result_t, request and register codes) and the
// dual_quadrature_counter_speed top level; runs directed and random encoder traffic.
module tb;
	import dqcs_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam longint SPEED_MAX = 64'sd2147483647;
	localparam longint SPEED_MIN = -64'sd2147483648;
	localparam int MAX_REPORTS = 40;
	localparam logic [WINDOW_W-1:0] LONG_WINDOW = 24'd200;
	// Pin walk whose consecutive pairs visit all sixteen {prev, cur} transitions.
	localparam logic [33:0] TRANSITION_WALK = {2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3,
		2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dual_quadrature_counter_speed dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block: registers, pin history, counts, baselines and held speeds.
	logic left_inv_q, right_inv_q;
	logic [WINDOW_W-1:0] window_q;
	logic [GAIN_W-1:0] gain_q;
	logic [1:0] left_ab_q, right_ab_q;
	logic armed_q;
	logic [COUNT_W-1:0] left_total_q, right_total_q, left_base_q, right_base_q;
	logic [WINDOW_W-1:0] ticks_q;
	logic [COUNT_W-1:0] left_spd_q, right_spd_q;

	result_t expected_readings[$];
	result_t want;

	// Encoder positions along the Gray cycle, and the way each wheel turns.
	logic [1:0] left_pos, right_pos;
	logic [1:0] left_dir, right_dir;

	int drv_idle_pct, rcv_idle_pct;
	int mismatch_count, readings_checked, windows_seen;
	int clears_sent, snapshots_sent, settings_count;

	// Toggle the clock every time unit: period of 2.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Map pin levels to a position on the Gray cycle 00 -> 10 -> 11 -> 01 (forward).
	function automatic logic [1:0] gray_position(input logic [1:0] ab);
		return {ab[0], ab[1] ^ ab[0]};
	endfunction

	// Count change for one wheel: one step forward, one back, or nothing
	// for a repeat or a jump across the cycle.
	function automatic logic [COUNT_W-1:0] pin_delta(input logic [1:0] from_ab,
			input logic [1:0] to_ab);
		logic [1:0] gap;
		gap = gray_position(to_ab) - gray_position(from_ab);
		if (gap == 2'd1)
			return 32'd1;
		if (gap == 2'd3)
			return '1;
		return '0;
	endfunction

	// Speed of one wheel over the closed window: floor((delta * gain) / 2^16), clamped.
	function automatic logic [COUNT_W-1:0] window_speed(input logic [COUNT_W-1:0] total,
			input logic [COUNT_W-1:0] base, input logic inv);
		logic [COUNT_W-1:0] delta;
		longint prod;
		delta = total - base;
		if (inv)
			delta = -delta;
		prod = longint'($signed(delta)) * longint'({32'd0, gain_q});
		prod = prod >>> Q_SHIFT;
		if (prod > SPEED_MAX)
			return 32'h7FFF_FFFF;
		if (prod < SPEED_MIN)
			return 32'h8000_0000;
		return prod[31:0];
	endfunction

	// Advance the shadow by one tick and return the reading it must produce.
	function automatic result_t predict_reading(input sample_t s);
		logic [1:0] lab, rab;
		logic [WINDOW_W-1:0] span;
		result_t r;
		lab = {s.left_a, s.left_b};
		rab = {s.right_a, s.right_b};
		span = (window_q == '0) ? 24'd1 : window_q;
		r = '0;
		// The very first tick only latches the pins.
		if (armed_q) begin
			left_total_q = left_total_q + pin_delta(left_ab_q, lab);
			right_total_q = right_total_q + pin_delta(right_ab_q, rab);
		end
		armed_q = 1'b1;
		left_ab_q = lab;
		right_ab_q = rab;
		if (s.req_type == REQ_CLEAR) begin
			// Clear drops counts, baselines and the window, but keeps held speeds.
			left_total_q = '0;
			right_total_q = '0;
			left_base_q = '0;
			right_base_q = '0;
			ticks_q = '0;
		end else begin
			ticks_q = ticks_q + 1'b1;
			if (ticks_q >= span) begin
				left_spd_q = window_speed(left_total_q, left_base_q, left_inv_q);
				right_spd_q = window_speed(right_total_q, right_base_q, right_inv_q);
				left_base_q = left_total_q;
				right_base_q = right_total_q;
				ticks_q = '0;
				r.speed_valid = 1'b1;
			end
		end
		r.left_count = left_inv_q ? -left_total_q : left_total_q;
		r.right_count = right_inv_q ? -right_total_q : right_total_q;
		// Snapshot reports first, then zeroes the counts; baselines stay.
		if (s.req_type == REQ_SNAPSHOT) begin
			left_total_q = '0;
			right_total_q = '0;
		end
		r.left_speed = left_spd_q;
		r.right_speed = right_spd_q;
		return r;
	endfunction

	function automatic sample_t make_sample(input logic [1:0] lab, input logic [1:0] rab,
			input logic [REQ_W-1:0] req);
		sample_t s;
		s.left_a = lab[1];
		s.left_b = lab[0];
		s.right_a = rab[1];
		s.right_b = rab[0];
		s.req_type = req;
		return s;
	endfunction

	// Pins for a Gray position (inverse of gray_position).
	function automatic logic [1:0] pins_at(input logic [1:0] pos);
		return {pos[0] ^ pos[1], pos[1]};
	endfunction

	// Offer one item; entered and left at a falling edge. Idle cycles drop valid,
	// the item is held until the block takes it, and the expectation is queued then.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < drv_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (sample_stall);
		expected_readings.push_back(predict_reading(s));
		if (s.req_type == REQ_CLEAR)
			clears_sent++;
		if (s.req_type == REQ_SNAPSHOT)
			snapshots_sent++;
		@(negedge clk);
	endtask

	// Move one wheel: mostly onward, sometimes hold, reverse, or jump two states.
	task automatic wander_wheel(inout logic [1:0] pos, inout logic [1:0] dir);
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			dir = -dir;
		else if (roll < 10)
			pos = pos;
		else if (roll < 15)
			pos = pos + 2'd2;
		else
			pos = pos + dir;
	endtask

	// Turn both wheels one tick and send the resulting pins with the given request.
	task automatic drive_wheels(input logic [REQ_W-1:0] req, input bit wander);
		if (wander) begin
			wander_wheel(left_pos, left_dir);
			wander_wheel(right_pos, right_dir);
		end else begin
			left_pos = left_pos + left_dir;
			right_pos = right_pos + right_dir;
		end
		send_sample(make_sample(pins_at(left_pos), pins_at(right_pos), req));
	endtask

	// Drop valid and hold off until every queued reading has come back.
	task automatic wait_for_readings();
		sample_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
	endtask

	// Write all four registers back to back; call only with the block idle.
	task automatic program_regs(input logic li, input logic ri,
			input logic [WINDOW_W-1:0] win, input logic [GAIN_W-1:0] gain);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LEFT_INVERT;
		cfg_data <= {31'd0, li};
		@(negedge clk);
		cfg_index <= CFG_RIGHT_INVERT;
		cfg_data <= {31'd0, ri};
		@(negedge clk);
		cfg_index <= CFG_SAMPLE_WINDOW;
		cfg_data <= {8'd0, win};
		@(negedge clk);
		cfg_index <= CFG_SPEED_GAIN;
		cfg_data <= gain;
		@(negedge clk);
		cfg_we <= 1'b0;
		left_inv_q = li;
		right_inv_q = ri;
		window_q = win;
		gain_q = gain;
		settings_count++;
	endtask

	// First tick after reset only latches pins; the next one counts from there.
	task automatic test_first_tick();
		send_sample(make_sample(2'b10, 2'b01, REQ_SAMPLE));
		send_sample(make_sample(2'b11, 2'b00, REQ_SAMPLE));
	endtask

	// Walk both wheels through every pin transition, legal and illegal.
	task automatic test_step_table();
		int i;
		logic [1:0] sym;
		for (i = 0; i < 17; i++) begin
			sym = TRANSITION_WALK[33 - 2 * i -: 2];
			send_sample(make_sample(sym, ~sym, REQ_SAMPLE));
		end
	endtask

	// Snapshot, clear, the unused code, a zero window, inversion and both gain extremes.
	task automatic test_requests();
		wait_for_readings();
		program_regs(1'b1, 1'b0, 24'd0, 32'hFFFF_FFFF);
		// Pick up the wheels where the transition walk left them.
		left_pos = 2'd0;
		right_pos = 2'd2;
		left_dir = 2'd1;
		right_dir = 2'd3;
		drive_wheels(REQ_SAMPLE, 1'b0);
		drive_wheels(REQ_SNAPSHOT, 1'b0);
		drive_wheels(REQ_UNUSED, 1'b0);
		drive_wheels(REQ_CLEAR, 1'b0);
		drive_wheels(REQ_SAMPLE, 1'b0);
		wait_for_readings();
		program_regs(1'b0, 1'b1, 24'd2, 32'd0);
		drive_wheels(REQ_SAMPLE, 1'b0);
		drive_wheels(REQ_SAMPLE, 1'b0);
		drive_wheels(REQ_SNAPSHOT, 1'b0);
	endtask

	// Spin both wheels forward through one long window at maximum gain so the
	// inverted left speed comes out large and negative, the right one large and positive.
	task automatic test_long_window();
		int i;
		wait_for_readings();
		drv_idle_pct = 0;
		rcv_idle_pct = 0;
		program_regs(1'b1, 1'b0, LONG_WINDOW, 32'hFFFF_FFFF);
		left_dir = 2'd1;
		right_dir = 2'd1;
		drive_wheels(REQ_CLEAR, 1'b0);
		for (i = 0; i < int'(LONG_WINDOW); i++)
			drive_wheels(REQ_SAMPLE, 1'b0);
		drive_wheels(REQ_SNAPSHOT, 1'b0);
		drive_wheels(REQ_SAMPLE, 1'b0);
	endtask

	// Random encoder motion in chunks, each under fresh register settings; the
	// idle mix moves from receiver-heavy to sender-heavy to none.
	task automatic test_random_motion();
		int chunk, i, roll;
		logic li, ri;
		logic [WINDOW_W-1:0] win;
		logic [GAIN_W-1:0] gain;
		logic [REQ_W-1:0] req;
		for (chunk = 0; chunk < 12; chunk++) begin
			wait_for_readings();
			if (chunk < 4) begin
				drv_idle_pct = 11;
				rcv_idle_pct = 66;
			end else if (chunk < 8) begin
				drv_idle_pct = 66;
				rcv_idle_pct = 11;
			end else begin
				drv_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			li = 1'($urandom_range(1));
			ri = 1'($urandom_range(1));
			case ($urandom_range(5))
				0: win = 24'd0;
				1: win = 24'd1;
				2: win = 24'hFF_FFFF;
				default: win = WINDOW_W'($urandom_range(24, 2));
			endcase
			case ($urandom_range(5))
				0: gain = 32'd0;
				1: gain = 32'hFFFF_FFFF;
				2: gain = GAIN_RESET;
				default: gain = $urandom;
			endcase
			program_regs(li, ri, win, gain);
			for (i = 0; i < 80; i++) begin
				roll = $urandom_range(99);
				if (roll < 92)
					req = REQ_SAMPLE;
				else if (roll < 95)
					req = REQ_SNAPSHOT;
				else if (roll < 98)
					req = REQ_CLEAR;
				else
					req = REQ_UNUSED;
				drive_wheels(req, 1'b1);
			end
		end
	endtask

	// Randomly stall the result side at the falling edge.
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < rcv_idle_pct);

	task automatic check_field(input string label, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, label,
					$signed(exp_v), $signed(got_v));
		end
	endtask

	// Compare every accepted reading with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				$display("%0t: reading with none expected, got %h", $time, result);
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (want.speed_valid)
					windows_seen++;
				check_field("left_count", want.left_count, result.left_count);
				check_field("right_count", want.right_count, result.right_count);
				check_field("left_speed", want.left_speed, result.left_speed);
				check_field("right_speed", want.right_speed, result.right_speed);
				check_field("speed_valid", {31'd0, want.speed_valid},
					{31'd0, result.speed_valid});
			end
		end
	end

	// Bound the run well beyond the slowest legal pass.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		// Drive every input to a known value and hold reset.
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_LEFT_INVERT;
		cfg_data = '0;
		drv_idle_pct = 11;
		rcv_idle_pct = 66;
		mismatch_count = 0;
		readings_checked = 0;
		windows_seen = 0;
		clears_sent = 0;
		snapshots_sent = 0;
		settings_count = 0;
		left_pos = 2'd0;
		right_pos = 2'd0;
		left_dir = 2'd1;
		right_dir = 2'd1;
		// Shadow starts from the reset state of the block.
		left_inv_q = 1'b0;
		right_inv_q = 1'b0;
		window_q = WINDOW_RESET;
		gain_q = GAIN_RESET;
		left_ab_q = '0;
		right_ab_q = '0;
		armed_q = 1'b0;
		left_total_q = '0;
		right_total_q = '0;
		left_base_q = '0;
		right_base_q = '0;
		ticks_q = '0;
		left_spd_q = '0;
		right_spd_q = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_tick();
		test_step_table();
		test_requests();
		test_long_window();
		test_random_motion();

		// Let the last readings drain, then let the clock run on before the summary.
		wait_for_readings();
		repeat (8) @(posedge clk);
		$display("Run covered %0d readings, %0d closed speed windows, %0d clears and %0d snapshots",
			readings_checked, windows_seen, clears_sent, snapshots_sent);
		$display("across %0d register settings, %0d field mismatches", settings_count,
			mismatch_count);
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
